// File: rtl/deq_pkg.sv
// Shared types and codes for the double-ended queue engine.
// No dependencies; deq_ctrl, the engine top and the testbench import this package.
package deq_pkg;

   localparam int RES_WIDTH = 32;
   localparam int OCC_WIDTH = 11;

   // Operation codes
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_SIZE       = 3'd4;
   localparam logic [2:0] OP_EMPTY      = 3'd5;
   localparam logic [2:0] OP_PEEK_FRONT = 3'd6;
   localparam logic [2:0] OP_PEEK_BACK  = 3'd7;

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Data returned by a pop or peek on an empty queue
   localparam logic [RES_WIDTH-1:0] DATA_NONE = '1;

   typedef struct packed {
      logic [2:0]                  operation;
      logic signed [RES_WIDTH-1:0] push_data;
   } req_item_type;

   typedef struct packed {
      logic signed [RES_WIDTH-1:0] result_data;
      logic [1:0]                  status;
      logic [OCC_WIDTH-1:0]        occupancy;
   } rsp_item_type;

   // Result under construction, waiting for the registered memory read
   typedef struct packed {
      logic                        valid;
      logic                        use_mem;
      logic [1:0]                  status;
      logic [RES_WIDTH-1:0]        data;
      logic [OCC_WIDTH-1:0]        occupancy;
   } pend_type;

endpackage

// File: rtl/deq_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Depends on nothing.
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on enable; the addressed entry is read every cycle (old data on a write)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/deq_ctrl.sv
// Pointer, count and result control for the double-ended queue engine.
// Depends on deq_pkg; drives the address and write port of deq_ram.
module deq_ctrl #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  deq_pkg::req_item_type      req_item,
   output logic                       mem_we,
   output logic [$clog2(DEPTH)-1:0]   mem_addr,
   output logic [DATA_WIDTH-1:0]      mem_wdata,
   output deq_pkg::pend_type          pend,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   import deq_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   logic [PW-1:0] front_ff, front_in;
   logic [PW-1:0] back_ff, back_in;
   logic [CW-1:0] count_ff, count_in;
   pend_type      pend_ff, pend_in;

   logic [PW-1:0] front_prev, front_next, back_prev, back_next;
   logic          is_empty, is_full;
   logic [DATA_WIDTH+RES_WIDTH-1:0] push_wide;
   logic [CW+RES_WIDTH-1:0]         size_wide;
   logic [CW+OCC_WIDTH-1:0]         occ_wide;

   // Ring neighbors of both pointers
   assign front_prev = (front_ff == '0) ? LAST_IDX : front_ff - PW'(1);
   assign front_next = (front_ff == LAST_IDX) ? '0 : front_ff + PW'(1);
   assign back_prev  = (back_ff == '0) ? LAST_IDX : back_ff - PW'(1);
   assign back_next  = (back_ff == LAST_IDX) ? '0 : back_ff + PW'(1);

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == FULL_CNT);

   // Store the low DATA_WIDTH bits of the pushed value, zero-extended
   assign push_wide = {{DATA_WIDTH{1'b0}}, req_item.push_data};
   assign mem_wdata = push_wide[DATA_WIDTH-1:0];
   assign size_wide = {{RES_WIDTH{1'b0}}, count_ff};
   assign occ_wide  = {{OCC_WIDTH{1'b0}}, count_in};

   // Decode the operation: one memory access, pointer and count updates
   always_comb begin
      front_in        = front_ff;
      back_in         = back_ff;
      count_in        = count_ff;
      mem_we          = 1'b0;
      mem_addr        = front_ff;
      pend_in.valid   = accept;
      pend_in.use_mem = 1'b0;
      pend_in.status  = ST_OK;
      pend_in.data    = '0;
      if (accept) begin
         case (req_item.operation)
            OP_PUSH_FRONT: begin
               mem_addr = front_prev;
               if (is_full) begin
                  pend_in.status = ST_FULL;
               end else begin
                  mem_we   = 1'b1;
                  front_in = front_prev;
                  count_in = count_ff + CW'(1);
               end
            end
            OP_PUSH_BACK: begin
               mem_addr = back_ff;
               if (is_full) begin
                  pend_in.status = ST_FULL;
               end else begin
                  mem_we   = 1'b1;
                  back_in  = back_next;
                  count_in = count_ff + CW'(1);
               end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
               mem_addr = front_ff;
               if (is_empty) begin
                  pend_in.status = ST_EMPTY;
                  pend_in.data   = DATA_NONE;
               end else begin
                  pend_in.use_mem = 1'b1;
                  if (req_item.operation == OP_POP_FRONT) begin
                     front_in = front_next;
                     count_in = count_ff - CW'(1);
                  end
               end
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
               mem_addr = back_prev;
               if (is_empty) begin
                  pend_in.status = ST_EMPTY;
                  pend_in.data   = DATA_NONE;
               end else begin
                  pend_in.use_mem = 1'b1;
                  if (req_item.operation == OP_POP_BACK) begin
                     back_in  = back_prev;
                     count_in = count_ff - CW'(1);
                  end
               end
            end
            OP_SIZE: begin
               pend_in.data = size_wide[RES_WIDTH-1:0];
            end
            OP_EMPTY: begin
               pend_in.data = is_empty ? RES_WIDTH'(1) : '0;
            end
            default: begin
               pend_in.data = '0;
            end
         endcase
      end
      pend_in.occupancy = occ_wide[OCC_WIDTH-1:0];
   end

   // Advance state on every edge; reset clears pointers, count and strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff      <= '0;
         back_ff       <= '0;
         count_ff      <= '0;
         pend_ff.valid <= 1'b0;
      end else begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   assign pend  = pend_ff;
   assign count = count_ff;

endmodule

// File: rtl/double_ended_queue_engine.sv
// Double-ended queue engine: one item accepted each cycle while busy is low,
// and its result strobed on rsp_strobe for one cycle, the cycle after
// acceptance. The delay comes from the registered read data of the entry RAM.
// Entries live in a ring buffer of DEPTH words of DATA_WIDTH bits; a push on
// a full queue is dropped with status full, and a pop or peek on an empty
// queue returns all ones with status empty. Results cannot be held off, so
// the receiver must take every beat in the cycle it is shown. Busy is high
// only while reset is asserted. Depends on deq_pkg, deq_ctrl and deq_ram.
module double_ended_queue_engine #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  deq_pkg::req_item_type req_item,
   output logic                  rsp_strobe,
   output deq_pkg::rsp_item_type rsp_item
);

   import deq_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic                  accept;
   logic                  mem_we;
   logic [PW-1:0]         mem_addr;
   logic [DATA_WIDTH-1:0] mem_wdata;
   logic [DATA_WIDTH-1:0] mem_rdata;
   logic [DATA_WIDTH+RES_WIDTH-1:0] rd_wide;
   pend_type              pend;
   logic [CW-1:0]         count;

   assign busy   = reset;
   assign accept = start & ~busy;

   deq_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_item  (req_item),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .pend      (pend),
      .count     (count)
   );

   deq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   // Merge the read word into the pending result
   assign rd_wide = {{RES_WIDTH{1'b0}}, mem_rdata};

   assign rsp_strobe           = pend.valid;
   assign rsp_item.result_data = pend.use_mem ? rd_wide[RES_WIDTH-1:0] : pend.data;
   assign rsp_item.status      = pend.status;
   assign rsp_item.occupancy   = pend.occupancy;

`ifndef SYNTH
   // Every accepted beat gives exactly one result in the next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (rsp_strobe == $past(accept)))
      else $error("result strobe does not follow accepted beat");

   // Occupancy never passes the ring size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= CW'(DEPTH))
      else $error("entry count exceeds depth");

   // Full status only answers a push
   a_full_on_push: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status == ST_FULL) |->
         ($past(req_item.operation) == OP_PUSH_FRONT ||
          $past(req_item.operation) == OP_PUSH_BACK))
      else $error("full status on a non-push operation");

   // A read-out result never carries an error status
   a_mem_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && pend.use_mem) |-> (rsp_item.status == ST_OK))
      else $error("memory data returned with error status");
`endif

endmodule

// File: test/double_ended_queue_engine_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the double-ended queue engine: directed and random beats,
// with a scoreboard class that predicts every result. Depends on deq_pkg and the RTL.
module double_ended_queue_engine_test;
   import deq_pkg::*;

   localparam int DEPTH       = 1024;
   localparam int TOTAL_BEATS  = 1950;
   localparam int TAIL_BEATS   = 100;
   localparam int STALL_LIMIT  = 1000;
   localparam int REPORT_LIMIT = 10;

   // Queue predictor and store of expected results
   class deque_scoreboard;
      logic [RES_WIDTH-1:0] entries [DEPTH];
      int                   front_index;
      int                   back_index;
      int                   entry_total;
      rsp_item_type         expected_responses [$];
      int                   error_count;

      function new();
         front_index = 0;
         back_index  = 0;
         entry_total = 0;
         error_count = 0;
      endfunction

      // Apply one operation to the shadow queue and build its result
      function rsp_item_type apply_operation(req_item_type item);
         rsp_item_type rsp;
         logic         is_empty;
         logic         is_full;
         rsp.result_data = '0;
         rsp.status      = ST_OK;
         is_empty = (entry_total == 0);
         is_full  = (entry_total >= DEPTH);
         if (is_empty && item.operation inside {OP_POP_FRONT, OP_POP_BACK,
                                                OP_PEEK_FRONT, OP_PEEK_BACK}) begin
            rsp.status      = ST_EMPTY;
            rsp.result_data = DATA_NONE;
         end else begin
            case (item.operation)
               OP_PUSH_FRONT, OP_PUSH_BACK: begin
                  if (is_full) begin
                     rsp.status = ST_FULL;
                  end else if (item.operation == OP_PUSH_FRONT) begin
                     front_index = (front_index + DEPTH - 1) % DEPTH;
                     entries[front_index] = item.push_data;
                     entry_total++;
                  end else begin
                     entries[back_index] = item.push_data;
                     back_index = (back_index + 1) % DEPTH;
                     entry_total++;
                  end
               end
               OP_POP_FRONT: begin
                  rsp.result_data = entries[front_index];
                  front_index = (front_index + 1) % DEPTH;
                  entry_total--;
               end
               OP_POP_BACK: begin
                  back_index = (back_index + DEPTH - 1) % DEPTH;
                  rsp.result_data = entries[back_index];
                  entry_total--;
               end
               OP_SIZE: begin
                  rsp.result_data = entry_total;
               end
               OP_EMPTY: begin
                  rsp.result_data = is_empty ? 1 : 0;
               end
               OP_PEEK_FRONT: begin
                  rsp.result_data = entries[front_index];
               end
               default: begin
                  rsp.result_data = entries[(back_index + DEPTH - 1) % DEPTH];
               end
            endcase
         end
         rsp.occupancy = OCC_WIDTH'(entry_total);
         return rsp;
      endfunction

      function void note_request(req_item_type item);
         expected_responses = {expected_responses, apply_operation(item)};
      endfunction

      // Compare one result beat against the oldest expectation
      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (expected_responses.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected result: data %h status %0d occupancy %0d",
                        got.result_data, got.status, got.occupancy);
         end else begin
            want = expected_responses[0];
            expected_responses.delete(0);
            if (got.result_data !== want.result_data || got.status !== want.status ||
                got.occupancy !== want.occupancy) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("result mismatch: data %h/%h status %0d/%0d occupancy %0d/%0d %s",
                           want.result_data, got.result_data, want.status, got.status,
                           want.occupancy, got.occupancy, "(expected/actual)");
            end
         end
      endfunction

      function int pending();
         return expected_responses.size();
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_strobe;
   rsp_item_type rsp_item;

   deque_scoreboard sb = new();
   int              beat_total;
   int              quiet_cycles;

   double_ended_queue_engine u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #6 clock = ~clock;

   // Check every result beat in the cycle it is shown
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_result(rsp_item);
   end

   // Count cycles in which no beat moves on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      quiet_cycles = 0;
      @(posedge clock);
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("double_ended_queue_engine_test: FAIL");
      $finish;
   end

   // Pick an operation: pushes and pops by percentage, queries for the rest
   function logic [2:0] pick_operation(int push_pct, int pop_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < push_pct)
         return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      else if (roll < push_pct + pop_pct)
         return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      else
         return 3'($urandom_range(OP_SIZE, OP_PEEK_BACK));
   endfunction

   // Drive one beat, hold until accepted, then maybe idle for a burst
   task send_beat(input logic [2:0] operation, input logic [RES_WIDTH-1:0] data,
                  input bit allow_idle);
      req_item_type item;
      item.operation = operation;
      item.push_data = data;
      req_item <= item;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(item);
      beat_total++;
      if (allow_idle && $urandom_range(0, 99) < 10) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   initial begin
      int tail;
      reset      = 1'b1;
      start      = 1'b0;
      req_item   = '0;
      beat_total = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Empty queue: pops and peeks report empty, size reports zero, empty reports one
      send_beat(OP_POP_FRONT,  $urandom(), 1'b0);
      send_beat(OP_POP_BACK,   $urandom(), 1'b0);
      send_beat(OP_PEEK_FRONT, $urandom(), 1'b0);
      send_beat(OP_PEEK_BACK,  $urandom(), 1'b0);
      send_beat(OP_SIZE,       $urandom(), 1'b0);
      send_beat(OP_EMPTY,      $urandom(), 1'b0);
      // Extreme values on both ends; a front push wraps the front pointer
      send_beat(OP_PUSH_FRONT, 32'h7fff_ffff, 1'b0);
      send_beat(OP_PUSH_BACK,  32'h8000_0000, 1'b0);
      send_beat(OP_PUSH_FRONT, 32'h0000_0000, 1'b0);
      send_beat(OP_PUSH_BACK,  32'hffff_ffff, 1'b0);
      send_beat(OP_PEEK_FRONT, $urandom(), 1'b0);
      send_beat(OP_PEEK_BACK,  $urandom(), 1'b0);
      send_beat(OP_SIZE,       $urandom(), 1'b0);
      send_beat(OP_EMPTY,      $urandom(), 1'b0);
      // Drain past empty from both ends
      send_beat(OP_POP_BACK,   $urandom(), 1'b0);
      send_beat(OP_POP_FRONT,  $urandom(), 1'b0);
      send_beat(OP_POP_BACK,   $urandom(), 1'b0);
      send_beat(OP_POP_FRONT,  $urandom(), 1'b0);
      send_beat(OP_POP_FRONT,  $urandom(), 1'b0);
      send_beat(OP_EMPTY,      $urandom(), 1'b0);

      // Low occupancy mix, touching empty often
      repeat (200) send_beat(pick_operation(40, 35), $urandom(), 1'b1);
      // Fill to full, then push against the bound
      while (sb.entry_total < DEPTH) send_beat(pick_operation(97, 1), $urandom(), 1'b1);
      repeat (20) send_beat(pick_operation(60, 10), $urandom(), 1'b1);
      // Drain down to half occupancy
      while (sb.entry_total > DEPTH / 2) send_beat(pick_operation(3, 92), $urandom(), 1'b1);
      // Back-to-back tail with no idling
      tail = 0;
      while (beat_total < TOTAL_BEATS || tail < TAIL_BEATS) begin
         send_beat(pick_operation(40, 35), $urandom(), 1'b0);
         tail++;
      end
      start <= 1'b0;

      // Wait out the last results, then a few more cycles
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.error_count == 0)
         $display("double_ended_queue_engine_test: PASS");
      else
         $display("double_ended_queue_engine_test: FAIL");
      $finish;
   end

endmodule

// File: filelist.f
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue_engine.sv
test/double_ended_queue_engine_test.sv
